>>> rtl/congestion_window_controller_core_assert.svh
// Assertion macros shared by the congestion window controller RTL.
// Expects clk and rst_n in scope at each use; compiled out under SYNTHESIS.
`ifndef CONGESTION_WINDOW_CONTROLLER_CORE_ASSERT_SVH
`define CONGESTION_WINDOW_CONTROLLER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define CWC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define CWC_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define CWC_ASSERT(label, prop, msg)
`define CWC_ASSERT_IMPL(label, ante, cons, msg)
`endif

`endif

>>> rtl/cwc_pkg.sv
// Shared types and constants for the congestion window controller.
// No dependencies; imported by cwc_step and the core top level.
package cwc_pkg;

    localparam int DUP_BITS      = 4;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [DUP_BITS-1:0]      DUP_MAX            = 4'd15;
    localparam logic [DUP_BITS-1:0]      DUP_LIMIT_RST      = 4'd3;
    localparam logic [CFG_DATA_BITS-1:0] INIT_THRESHOLD_RST = 16'd128;

    localparam logic CFG_INITIAL_THRESHOLD = 1'b0;
    localparam logic CFG_DUP_ACK_LIMIT     = 1'b1;

    localparam logic KIND_ACK     = 1'b0;
    localparam logic KIND_TIMEOUT = 1'b1;

    typedef enum logic [1:0] {
        PH_SLOW  = 2'd0,
        PH_AVOID = 2'd1,
        PH_FAST  = 2'd2
    } phase_t;

    typedef struct packed {
        phase_t              phase;
        logic [DUP_BITS-1:0] dup_count;
        logic                last_valid;
    } cwc_ctrl_t;

endpackage

>>> rtl/cwc_step.sv
// Combinational per-event update of the congestion window state.
// Depends on cwc_pkg for the phase codes and the control struct.
module cwc_step #(
    parameter int WINDOW_BITS = 16,
    parameter int SEQ_BITS    = 16
) (
    input  logic                         kind,
    input  logic [SEQ_BITS-1:0]          ack_number,
    input  logic [cwc_pkg::DUP_BITS-1:0] dup_limit,
    input  logic [WINDOW_BITS-1:0]       cwnd,
    input  logic [WINDOW_BITS-1:0]       ssthresh,
    input  logic [SEQ_BITS-1:0]          last_ack,
    input  logic [SEQ_BITS-1:0]          base,
    input  cwc_pkg::cwc_ctrl_t           ctrl,
    output logic [WINDOW_BITS-1:0]       cwnd_out,
    output logic [WINDOW_BITS-1:0]       ssthresh_out,
    output logic [SEQ_BITS-1:0]          last_ack_out,
    output logic [SEQ_BITS-1:0]          base_out,
    output cwc_pkg::cwc_ctrl_t           ctrl_out,
    output logic                         retransmit,
    output logic [SEQ_BITS-1:0]          retransmit_seq
);
    import cwc_pkg::*;

    localparam logic [WINDOW_BITS-1:0] WIN_MAX = {WINDOW_BITS{1'b1}};
    localparam logic [WINDOW_BITS-1:0] WIN_ONE = WINDOW_BITS'(1);

    logic [WINDOW_BITS:0]   inc_w;
    logic [WINDOW_BITS:0]   dbl_w;
    logic [WINDOW_BITS:0]   thr3_w;
    logic [WINDOW_BITS-1:0] cwnd_inc;
    logic [WINDOW_BITS-1:0] cwnd_dbl;
    logic [WINDOW_BITS-1:0] half;
    logic [WINDOW_BITS-1:0] ss_floor;
    logic [WINDOW_BITS-1:0] ss_cwnd;
    logic                   grow;
    logic                   is_dup;
    logic                   is_new;
    logic [DUP_BITS-1:0]    dup_inc;

    always_comb
    begin
        inc_w    = {1'b0, cwnd} + (WINDOW_BITS + 1)'(1);
        cwnd_inc = inc_w[WINDOW_BITS] ? WIN_MAX : inc_w[WINDOW_BITS-1:0];
        dbl_w    = {cwnd, 1'b0};
        cwnd_dbl = dbl_w[WINDOW_BITS] ? WIN_MAX : dbl_w[WINDOW_BITS-1:0];
        half     = cwnd >> 1;
        thr3_w   = {1'b0, half} + (WINDOW_BITS + 1)'(3);
        ss_floor = (ssthresh == '0) ? WIN_ONE : ssthresh;
        grow     = (dbl_w >= {1'b0, ssthresh});
        ss_cwnd  = grow ? cwnd_inc : cwnd_dbl;
        is_dup   = ctrl.last_valid && (ack_number == last_ack);
        is_new   = !ctrl.last_valid || (ack_number > last_ack);
        dup_inc  = (ctrl.dup_count == DUP_MAX) ? ctrl.dup_count
                                                : ctrl.dup_count + DUP_BITS'(1);

        cwnd_out       = cwnd;
        ssthresh_out   = ssthresh;
        last_ack_out   = last_ack;
        base_out       = base;
        ctrl_out       = ctrl;
        retransmit     = 1'b0;
        retransmit_seq = '0;

        if (kind == KIND_TIMEOUT)
        begin
            cwnd_out       = WIN_ONE;
            ctrl_out.phase = PH_SLOW;
        end
        else if (is_dup)
        begin
            ctrl_out.dup_count = dup_inc;
            if (ctrl.phase == PH_FAST)
            begin
                cwnd_out = cwnd_inc;
            end
            else if (dup_inc == dup_limit)
            begin
                ssthresh_out   = half;
                cwnd_out       = thr3_w[WINDOW_BITS] ? WIN_MAX : thr3_w[WINDOW_BITS-1:0];
                ctrl_out.phase = PH_FAST;
                retransmit     = 1'b1;
                retransmit_seq = ack_number;
            end
        end
        else if (is_new)
        begin
            ctrl_out.dup_count  = '0;
            ctrl_out.last_valid = 1'b1;
            last_ack_out        = ack_number;
            base_out            = ack_number;
            case (ctrl.phase)
                PH_SLOW:
                begin
                    cwnd_out       = ss_cwnd;
                    ctrl_out.phase = (grow || (ss_cwnd >= ssthresh)) ? PH_AVOID : PH_SLOW;
                end
                PH_AVOID:
                begin
                    cwnd_out = cwnd_inc;
                end
                default:
                begin
                    cwnd_out       = ss_floor;
                    ctrl_out.phase = PH_AVOID;
                end
            endcase
        end
    end

endmodule

>>> rtl/congestion_window_controller_core.sv
// Top level of the congestion window controller: input register, window state,
// result register. Depends on cwc_pkg, cwc_step and the assertion macro header.
`include "congestion_window_controller_core_assert.svh"

// Reno-style congestion window controller. Each input transaction is an ack
// number or a timeout; each produces exactly one result transaction with the
// updated window, threshold, phase, window base and any fast-retransmit
// request. One transaction is taken per cycle while in_stall is low; a new
// one can be accepted as the previous one leaves the input register. The input
// register loads at the accepting edge; the combinational state update then
// loads the window state and the result register together once the result
// register can advance. Writing initial_threshold also reloads the threshold.
module congestion_window_controller_core #(
    parameter int WINDOW_BITS = 16,
    parameter int SEQ_BITS    = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              cfg_write,
    input  logic                              cfg_index,
    input  logic [cwc_pkg::CFG_DATA_BITS-1:0] cfg_data,

    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              kind,
    input  logic [SEQ_BITS-1:0]               ack_number,

    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [WINDOW_BITS-1:0]            window_size,
    output logic [WINDOW_BITS-1:0]            threshold,
    output logic [1:0]                        phase,
    output logic                              retransmit,
    output logic [SEQ_BITS-1:0]               retransmit_seq,
    output logic [SEQ_BITS-1:0]               window_base
);
    import cwc_pkg::*;

    localparam logic [WINDOW_BITS-1:0] WIN_MAX = {WINDOW_BITS{1'b1}};
    localparam logic [WINDOW_BITS-1:0] WIN_ONE = WINDOW_BITS'(1);
    localparam logic [WINDOW_BITS-1:0] THR_RST = WINDOW_BITS'(INIT_THRESHOLD_RST);

    // input register
    logic                s1_valid_reg, s1_valid_next;
    logic                kind_reg;
    logic [SEQ_BITS-1:0] ack_reg;

    // window state
    logic [WINDOW_BITS-1:0] cwnd_reg, cwnd_next;
    logic [WINDOW_BITS-1:0] ssthresh_reg, ssthresh_next;
    logic [SEQ_BITS-1:0]    last_ack_reg, last_ack_next;
    logic [SEQ_BITS-1:0]    base_reg, base_next;
    cwc_ctrl_t              ctrl_reg, ctrl_next;
    logic [DUP_BITS-1:0]    dup_limit_reg, dup_limit_next;

    // result register
    logic                   out_valid_reg, out_valid_next;
    logic [WINDOW_BITS-1:0] win_out_reg;
    logic [WINDOW_BITS-1:0] thr_out_reg;
    phase_t                 phase_out_reg;
    logic                   rtx_reg;
    logic [SEQ_BITS-1:0]    rtx_seq_reg;
    logic [SEQ_BITS-1:0]    base_out_reg;

    logic                   advance;
    logic                   fire;
    logic                   accept;
    logic [WINDOW_BITS-1:0] thr_load;

    logic [WINDOW_BITS-1:0] step_cwnd;
    logic [WINDOW_BITS-1:0] step_ssthresh;
    logic [SEQ_BITS-1:0]    step_last_ack;
    logic [SEQ_BITS-1:0]    step_base;
    cwc_ctrl_t              step_ctrl;
    logic                   step_rtx;
    logic [SEQ_BITS-1:0]    step_rtx_seq;

    cwc_step #(
        .WINDOW_BITS (WINDOW_BITS),
        .SEQ_BITS    (SEQ_BITS)
    ) u_step (
        .kind           (kind_reg),
        .ack_number     (ack_reg),
        .dup_limit      (dup_limit_reg),
        .cwnd           (cwnd_reg),
        .ssthresh       (ssthresh_reg),
        .last_ack       (last_ack_reg),
        .base           (base_reg),
        .ctrl           (ctrl_reg),
        .cwnd_out       (step_cwnd),
        .ssthresh_out   (step_ssthresh),
        .last_ack_out   (step_last_ack),
        .base_out       (step_base),
        .ctrl_out       (step_ctrl),
        .retransmit     (step_rtx),
        .retransmit_seq (step_rtx_seq)
    );

    assign advance  = !out_valid_reg || !out_stall;
    assign fire     = s1_valid_reg && advance;
    assign in_stall = s1_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    assign thr_load = (33'(cfg_data) > 33'(WIN_MAX)) ? WIN_MAX : WINDOW_BITS'(cfg_data);

    always_comb
    begin
        s1_valid_next  = accept ? 1'b1 : (fire ? 1'b0 : s1_valid_reg);
        out_valid_next = advance ? s1_valid_reg : out_valid_reg;

        cwnd_next      = fire ? step_cwnd     : cwnd_reg;
        ssthresh_next  = fire ? step_ssthresh : ssthresh_reg;
        last_ack_next  = fire ? step_last_ack : last_ack_reg;
        base_next      = fire ? step_base     : base_reg;
        ctrl_next      = fire ? step_ctrl     : ctrl_reg;
        dup_limit_next = dup_limit_reg;

        if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_INITIAL_THRESHOLD: ssthresh_next  = thr_load;
                CFG_DUP_ACK_LIMIT:     dup_limit_next = cfg_data[DUP_BITS-1:0];
                default:               dup_limit_next = dup_limit_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg         <= 1'b0;
            out_valid_reg        <= 1'b0;
            cwnd_reg             <= WIN_ONE;
            ssthresh_reg         <= THR_RST;
            last_ack_reg         <= '0;
            base_reg             <= '0;
            ctrl_reg.phase       <= PH_SLOW;
            ctrl_reg.dup_count   <= '0;
            ctrl_reg.last_valid  <= 1'b0;
            dup_limit_reg        <= DUP_LIMIT_RST;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            cwnd_reg      <= cwnd_next;
            ssthresh_reg  <= ssthresh_next;
            last_ack_reg  <= last_ack_next;
            base_reg      <= base_next;
            ctrl_reg      <= ctrl_next;
            dup_limit_reg <= dup_limit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= kind;
            ack_reg  <= ack_number;
        end
        if (fire)
        begin
            win_out_reg   <= step_cwnd;
            thr_out_reg   <= step_ssthresh;
            phase_out_reg <= step_ctrl.phase;
            rtx_reg       <= step_rtx;
            rtx_seq_reg   <= step_rtx_seq;
            base_out_reg  <= step_base;
        end
    end

    assign out_valid      = out_valid_reg;
    assign window_size    = win_out_reg;
    assign threshold      = thr_out_reg;
    assign phase          = phase_out_reg;
    assign retransmit     = rtx_reg;
    assign retransmit_seq = rtx_seq_reg;
    assign window_base    = base_out_reg;

    `CWC_ASSERT(a_cwnd_nonzero, cwnd_reg != '0, "congestion window reached zero")
    `CWC_ASSERT_IMPL(a_rtx_in_fast, out_valid && rtx_reg, phase == PH_FAST, "rtx outside recovery")
    `CWC_ASSERT_IMPL(a_seq_idle, out_valid && !rtx_reg, rtx_seq_reg == '0, "stray rtx sequence")
    `CWC_ASSERT_IMPL(a_out_win_nonzero, out_valid, win_out_reg != '0, "result window is zero")

endmodule
